@@ rtl/icmper_pkg.sv @@
package icmper_pkg;

	// Fixed field widths of the two channels.
	localparam int IDX_W  = 11;
	localparam int RLEN_W = 12;

	// Operation codes of an input item.
	localparam logic OP_PUSH  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	// Kinds of result item.
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_BYTE    = 1'b1;

	// Verdict codes.
	localparam logic [2:0] STAT_READY     = 3'd0;
	localparam logic [2:0] STAT_TOO_SHORT = 3'd1;
	localparam logic [2:0] STAT_NOT_ICMP  = 3'd2;
	localparam logic [2:0] STAT_NOT_ECHO  = 3'd3;
	localparam logic [2:0] STAT_OVERSIZE  = 3'd4;

	// Protocol constants.
	localparam int         MIN_LEN      = 28;
	localparam int         ICMP_HDR_LEN = 8;
	localparam logic [3:0] IHL_MASK     = 4'hF;
	localparam logic [7:0] PROTO_ICMP   = 8'd1;
	localparam logic [7:0] ECHO_REQUEST = 8'd8;
	localparam logic [7:0] ECHO_REPLY   = 8'd0;

	// Byte positions inside the packet.
	localparam int PROTO_POS   = 9;
	localparam int IP_CK_POS   = 10;
	localparam int ADDR_POS    = 12;
	localparam int ICMP_CK_OFS = 2;

	typedef struct packed {
		logic              operation;
		logic [7:0]        data_byte;
		logic              last;
		logic [IDX_W-1:0]  index;
	} item_t;

	typedef struct packed {
		logic              result_kind;
		logic [2:0]        status;
		logic [RLEN_W-1:0] reply_length;
		logic [7:0]        reply_byte;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FETCH,
		S_V_PROTO,
		S_V_IHL,
		S_V_TYPE,
		S_SWAP_RD,
		S_SWAP_WR,
		S_ICMP_CLR,
		S_ICMP_SUM,
		S_ICMP_CK,
		S_IP_CLR,
		S_IP_SUM,
		S_IP_CK,
		S_VERDICT
	} icmper_state_t;

endpackage

@@ rtl/icmp_echo_responder_unit.sv @@
// ICMP echo responder.
// The item channel (item_valid, item_stall, item) carries two kinds of item. A push
// writes one byte of an IPv4 packet into the packet memory; the push marked last
// closes the packet, and the unit then judges it and, if it is an echo request,
// rewrites it into the echo reply in place. A fetch reads one byte of the stored
// reply. The result channel (result_valid, result_stall, result) returns one verdict
// item for every last push and one byte item for every fetch.
// A push that is not last keeps the unit in S_IDLE, so the next item is taken at once.
// A fetch reads the memory at the edge that accepts it; in S_FETCH the byte item
// enters the output register once it is free, then S_IDLE takes the next item.
// A packet that is dropped gives its verdict from S_VERDICT, reached from the state
// whose check fails (S_V_PROTO, S_V_IHL or S_V_TYPE).
// A packet that is answered is rewritten between its last byte and its verdict:
// every step of the rewrite (address swap, type change, ICMP checksum over the ICMP
// part, IP checksum over the IP header) uses the packet memory, one byte per cycle.
// While a packet is being judged or a fetch is in flight, item_stall is high.
// A result that waits in the output register under result_stall does not block
// pushes; a fetch or verdict waits in its last state until the register is free.
// Reset clears the byte count, the overflow flag, the stored reply length and all
// control state; the packet memory itself is not cleared, and nothing reads a
// byte that was never written.
module icmp_echo_responder_unit #(
	parameter int MAX_BYTES = 2048
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  icmper_pkg::item_t        item,
	output logic                     result_valid,
	input  logic                     result_stall,
	output icmper_pkg::result_t      result
);
	import icmper_pkg::*;

	localparam int AW = $clog2(MAX_BYTES);
	localparam int LW = $clog2(MAX_BYTES + 1);
	localparam int CW = (LW > RLEN_W) ? LW + 1 : RLEN_W + 1;
	localparam int XW = (AW > IDX_W) ? AW : IDX_W;

	// Packet memory: one write port and one registered read port.
	logic [7:0]    pkt_mem [MAX_BYTES];
	logic [7:0]    mem_rd_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;

	icmper_state_t state_q, state_d;

	logic [LW-1:0] byte_count_q;
	logic          overflow_q;
	logic [LW-1:0] stored_len_q;
	logic [5:0]    hdr_q;
	logic [2:0]    status_q;
	logic          fetch_ok_q;
	logic [2:0]    step_q;
	logic [LW-1:0] ptr_q;
	logic [15:0]   sum_q;
	logic [7:0]    swap_buf_q [8];

	// Read pipeline tags: what the data in mem_rd_q is for.
	logic          swap_cap_s1;
	logic [2:0]    swap_tag_s1;
	logic          sum_pend_s1;
	logic          sum_hi_s1;

	result_t       result_q, result_d;
	logic          result_valid_q;

	// Control strobes from the state machine.
	logic          status_set;
	logic [2:0]    status_d;
	logic          hdr_load;
	logic [5:0]    hdr_d;
	logic          step_clr, step_inc;
	logic          ptr_set, ptr_inc;
	logic [LW-1:0] ptr_d;
	logic          sum_clr, sum_issue, swap_issue;
	logic          load_out, verdict_done;

	logic          out_room;
	logic          push_acc, fetch_acc, store_room;
	logic [CW-1:0] len_x;
	logic [XW-1:0] idx_x;
	logic [16:0]   sum_raw;
	logic [15:0]   sum_next;
	logic [15:0]   ck;
	logic [LW-1:0] new_stored_len;

	assign out_room   = !result_valid_q || !result_stall;
	assign push_acc   = (state_q == S_IDLE) && item_valid && (item.operation == OP_PUSH);
	assign fetch_acc  = (state_q == S_IDLE) && item_valid && (item.operation == OP_FETCH);
	assign len_x      = CW'(byte_count_q);
	assign store_room = len_x < CW'(MAX_BYTES);
	assign idx_x      = XW'(item.index);
	assign ck         = ~sum_q;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// End-around carry: adding a byte in its lane keeps the ones'-complement sum.
	assign sum_raw  = {1'b0, sum_q} + {1'b0, (sum_hi_s1 ? {mem_rd_q, 8'h00} : {8'h00, mem_rd_q})};
	assign sum_next = sum_raw[15:0] + 16'(sum_raw[16]);

	assign new_stored_len = (status_q == STAT_READY) ? byte_count_q : '0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pkt_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= pkt_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = '0;
		mem_re       = 1'b0;
		mem_raddr    = '0;
		status_set   = 1'b0;
		status_d     = STAT_READY;
		hdr_load     = 1'b0;
		hdr_d        = {mem_rd_q[3:0] & IHL_MASK, 2'b00};
		step_clr     = 1'b0;
		step_inc     = 1'b0;
		ptr_set      = 1'b0;
		ptr_inc      = 1'b0;
		ptr_d        = '0;
		sum_clr      = 1'b0;
		sum_issue    = 1'b0;
		swap_issue   = 1'b0;
		load_out     = 1'b0;
		verdict_done = 1'b0;
		result_d     = '0;
		case (state_q)
			S_IDLE: begin
				if (fetch_acc) begin
					mem_re    = 1'b1;
					mem_raddr = idx_x[AW-1:0];
					state_d   = S_FETCH;
				end else if (push_acc) begin
					if (store_room) begin
						mem_we    = 1'b1;
						mem_waddr = byte_count_q[AW-1:0];
						mem_wdata = item.data_byte;
					end
					if (item.last) begin
						mem_re    = 1'b1;
						mem_raddr = AW'(PROTO_POS);
						state_d   = S_V_PROTO;
					end
				end
			end
			S_FETCH: begin
				if (out_room) begin
					load_out              = 1'b1;
					result_d.result_kind  = KIND_BYTE;
					result_d.status       = STAT_READY;
					result_d.reply_length = RLEN_W'(CW'(stored_len_q));
					result_d.reply_byte   = fetch_ok_q ? mem_rd_q : 8'h00;
					state_d               = S_IDLE;
				end
			end
			S_V_PROTO: begin
				if (len_x < CW'(MIN_LEN)) begin
					status_set = 1'b1;
					status_d   = STAT_TOO_SHORT;
					state_d    = S_VERDICT;
				end else if (mem_rd_q != PROTO_ICMP) begin
					status_set = 1'b1;
					status_d   = STAT_NOT_ICMP;
					state_d    = S_VERDICT;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = '0;
					state_d   = S_V_IHL;
				end
			end
			S_V_IHL: begin
				hdr_load = 1'b1;
				if (len_x < CW'(hdr_d) + CW'(ICMP_HDR_LEN)) begin
					status_set = 1'b1;
					status_d   = STAT_TOO_SHORT;
					state_d    = S_VERDICT;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'(hdr_d);
					state_d   = S_V_TYPE;
				end
			end
			S_V_TYPE: begin
				if (mem_rd_q != ECHO_REQUEST) begin
					status_set = 1'b1;
					status_d   = STAT_NOT_ECHO;
					state_d    = S_VERDICT;
				end else if (overflow_q) begin
					status_set = 1'b1;
					status_d   = STAT_OVERSIZE;
					state_d    = S_VERDICT;
				end else begin
					step_clr = 1'b1;
					state_d  = S_SWAP_RD;
				end
			end
			S_SWAP_RD: begin
				mem_re     = 1'b1;
				mem_raddr  = AW'(ADDR_POS) + AW'(step_q);
				swap_issue = 1'b1;
				if (step_q == 3'd7) begin
					step_clr = 1'b1;
					state_d  = S_SWAP_WR;
				end else begin
					step_inc = 1'b1;
				end
			end
			S_SWAP_WR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(ADDR_POS) + AW'(step_q);
				mem_wdata = swap_buf_q[step_q ^ 3'd4];
				if (step_q == 3'd7) begin
					step_clr = 1'b1;
					state_d  = S_ICMP_CLR;
				end else begin
					step_inc = 1'b1;
				end
			end
			S_ICMP_CLR: begin
				mem_we = 1'b1;
				case (step_q)
					3'd0: begin
						mem_waddr = AW'(hdr_q);
						mem_wdata = ECHO_REPLY;
					end
					3'd1: mem_waddr = AW'(hdr_q) + AW'(ICMP_CK_OFS);
					default: mem_waddr = AW'(hdr_q) + AW'(ICMP_CK_OFS + 1);
				endcase
				if (step_q == 3'd2) begin
					ptr_set = 1'b1;
					ptr_d   = LW'(hdr_q);
					sum_clr = 1'b1;
					state_d = S_ICMP_SUM;
				end else begin
					step_inc = 1'b1;
				end
			end
			S_ICMP_SUM: begin
				if (ptr_q < byte_count_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q[AW-1:0];
					ptr_inc   = 1'b1;
					sum_issue = 1'b1;
				end else if (!sum_pend_s1) begin
					step_clr = 1'b1;
					state_d  = S_ICMP_CK;
				end
			end
			S_ICMP_CK: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(hdr_q) + AW'(ICMP_CK_OFS) + AW'(step_q[0]);
				mem_wdata = step_q[0] ? ck[7:0] : ck[15:8];
				if (step_q[0]) begin
					step_clr = 1'b1;
					state_d  = S_IP_CLR;
				end else begin
					step_inc = 1'b1;
				end
			end
			S_IP_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(IP_CK_POS) + AW'(step_q[0]);
				if (step_q[0]) begin
					ptr_set = 1'b1;
					sum_clr = 1'b1;
					state_d = S_IP_SUM;
				end else begin
					step_inc = 1'b1;
				end
			end
			S_IP_SUM: begin
				if (CW'(ptr_q) < CW'(hdr_q)) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q[AW-1:0];
					ptr_inc   = 1'b1;
					sum_issue = 1'b1;
				end else if (!sum_pend_s1) begin
					step_clr = 1'b1;
					state_d  = S_IP_CK;
				end
			end
			S_IP_CK: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(IP_CK_POS) + AW'(step_q[0]);
				mem_wdata = step_q[0] ? ck[7:0] : ck[15:8];
				if (step_q[0]) begin
					status_set = 1'b1;
					status_d   = STAT_READY;
					state_d    = S_VERDICT;
				end else begin
					step_inc = 1'b1;
				end
			end
			S_VERDICT: begin
				if (out_room) begin
					load_out              = 1'b1;
					verdict_done          = 1'b1;
					result_d.result_kind  = KIND_VERDICT;
					result_d.status       = status_q;
					result_d.reply_length = RLEN_W'(CW'(new_stored_len));
					result_d.reply_byte   = 8'h00;
					state_d               = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Packet bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			overflow_q   <= 1'b0;
			stored_len_q <= '0;
		end else if (verdict_done) begin
			byte_count_q <= '0;
			overflow_q   <= 1'b0;
			stored_len_q <= new_stored_len;
		end else if (push_acc) begin
			if (store_room) begin
				byte_count_q <= byte_count_q + LW'(1);
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			ptr_q       <= '0;
			swap_cap_s1 <= 1'b0;
			sum_pend_s1 <= 1'b0;
		end else begin
			if (step_clr) begin
				step_q <= '0;
			end else if (step_inc) begin
				step_q <= step_q + 3'd1;
			end
			if (ptr_set) begin
				ptr_q <= ptr_d;
			end else if (ptr_inc) begin
				ptr_q <= ptr_q + LW'(1);
			end
			swap_cap_s1 <= swap_issue;
			sum_pend_s1 <= sum_issue;
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		swap_tag_s1 <= step_q;
		sum_hi_s1   <= ~ptr_q[0];
		if (status_set) begin
			status_q <= status_d;
		end
		if (hdr_load) begin
			hdr_q <= hdr_d;
		end
		if (fetch_acc) begin
			fetch_ok_q <= (CW'(item.index) < CW'(stored_len_q))
				&& (CW'(item.index) < CW'(MAX_BYTES));
		end
		if (swap_cap_s1) begin
			swap_buf_q[swap_tag_s1] <= mem_rd_q;
		end
		if (sum_clr) begin
			sum_q <= '0;
		end else if (sum_pend_s1) begin
			sum_q <= sum_next;
		end
		if (load_out) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

endmodule
